FILE: rtl/core/fdp_pkg.sv
package fdp_pkg;

   localparam int EXP_W     = 12;
   localparam int MANT_W    = 61;
   localparam int SUM_W     = 62;
   localparam int PROD_W    = 48;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam logic [31:0] ZERO_BITS = 32'h0000_0000;

   typedef logic signed [EXP_W-1:0] exp_type;

   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
   } class_type;

   typedef struct packed {
      logic [23:0] mant;
      exp_type     exp;
   } unpacked_type;

   // exact product, normalized so that bit MANT_W-1 is set
   typedef struct packed {
      logic              last;
      logic              nan;
      logic              inf;
      logic              zero;
      logic              sign;
      logic [MANT_W-1:0] mant;
      exp_type           exp;
   } prod_type;

   function automatic class_type classify(input logic [31:0] x);
      class_type c;
      c.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      c.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      c.zero = (x[30:23] == 8'h00) && (x[22:0] == 23'd0);
      return c;
   endfunction

   // value = mant * 2^exp
   function automatic unpacked_type unpack(input logic [31:0] x);
      unpacked_type u;
      if (x[30:23] == 8'h00) begin
         u.mant = {1'b0, x[22:0]};
         u.exp  = exp_type'(-149);
      end else begin
         u.mant = {1'b1, x[22:0]};
         u.exp  = exp_type'({4'b0, x[30:23]}) - exp_type'(150);
      end
      return u;
   endfunction

   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

endpackage

FILE: rtl/core/fdp_front.sv
module fdp_front import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_a,
   input  logic [31:0] in_b,
   input  logic        in_last,
   output logic [1:0]  inflight,
   output logic        q_push,
   output prod_type    q_wdata
);

   logic        s1_v_ff;
   logic [31:0] s1_a_ff;
   logic [31:0] s1_b_ff;
   logic        s1_last_ff;

   logic              s2_v_ff;
   logic [PROD_W-1:0] s2_mp_ff;
   exp_type           s2_ep_ff;
   logic              s2_sign_ff;
   class_type         s2_cls_ff;
   logic              s2_last_ff;

   class_type    ca, cb, pcls_in;
   unpacked_type ua, ub;
   logic [5:0]   k;

   always_comb begin
      ca = classify(s1_a_ff);
      cb = classify(s1_b_ff);
      ua = unpack(s1_a_ff);
      ub = unpack(s1_b_ff);
      pcls_in.nan  = ca.nan | cb.nan | (ca.inf & cb.zero) | (cb.inf & ca.zero);
      pcls_in.inf  = (ca.inf | cb.inf) & ~pcls_in.nan;
      pcls_in.zero = (ca.zero | cb.zero) & ~pcls_in.nan & ~pcls_in.inf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
      end
      s1_a_ff    <= in_a;
      s1_b_ff    <= in_b;
      s1_last_ff <= in_last;
      s2_mp_ff   <= ua.mant * ub.mant;
      s2_ep_ff   <= ua.exp + ub.exp;
      s2_sign_ff <= s1_a_ff[31] ^ s1_b_ff[31];
      s2_cls_ff  <= pcls_in;
      s2_last_ff <= s1_last_ff;
   end

   // normalize the product so its leading one sits at bit 60
   always_comb begin
      k = msb_pos({16'b0, s2_mp_ff});
      q_wdata.last = s2_last_ff;
      q_wdata.nan  = s2_cls_ff.nan;
      q_wdata.inf  = s2_cls_ff.inf;
      q_wdata.zero = s2_cls_ff.zero;
      q_wdata.sign = s2_sign_ff;
      q_wdata.mant = {13'b0, s2_mp_ff} << (6'd60 - k);
      q_wdata.exp  = s2_ep_ff + exp_type'({6'b0, k});
   end

   assign q_push   = s2_v_ff;
   assign inflight = {1'b0, s1_v_ff} + {1'b0, s2_v_ff};

endmodule

FILE: rtl/core/fdp_queue.sv
module fdp_queue import fdp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prod_type          wdata,
   input  logic              pop,
   output prod_type          rdata,
   output logic              q_empty,
   output logic [QCNT_W-1:0] count
);

   prod_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata   = mem_ff[rd_ptr_ff];
   assign q_empty = (count_ff == '0);
   assign count   = count_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == QCNT_W'(QDEPTH)))
      else $error("request queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("request queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("request queue count out of range");
`endif

endmodule

FILE: rtl/core/fdp_back.sv
module fdp_back import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  prod_type    q_rdata,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_sum
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWAP  = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_NORM  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [31:0]       sum_ff, sum_in;
   prod_type          item_ff;

   logic [MANT_W-1:0] big_m_ff, big_m_in, small_m_ff, small_m_in;
   exp_type           big_e_ff, big_e_in, small_e_ff, small_e_in;
   logic              big_s_ff, big_s_in, small_s_ff, small_s_in;
   logic              spec_v_ff, spec_v_in;
   logic [31:0]       spec_bits_ff, spec_bits_in;

   logic [SUM_W-1:0]  r_ff, r_in;
   logic [SUM_W-1:0]  rn_ff, rn_in;
   exp_type           top_ff, top_in;
   logic              zero_ff, zero_in;

   logic [31:0]          rb_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rb_wr_ff, rb_rd_ff;
   logic [RSP_CNT_W-1:0] rb_cnt_ff;
   logic                 rb_push, rb_pop;

   class_type         cc;
   unpacked_type      uc;
   logic [5:0]        kc;
   logic [MANT_W-1:0] my;
   exp_type           ey;
   logic              swap;

   exp_type           d;
   logic [5:0]        sh;
   logic [MANT_W-1:0] ys;

   logic [5:0]        p;

   exp_type           diff, lsb_e, lsb2;
   logic [5:0]        extra;
   logic [SUM_W-1:0]  t;
   logic              sticky_x, guard, rest, up;
   logic [23:0]       q, qf;
   logic [24:0]       q2;
   exp_type           biased;
   logic [31:0]       packed_bits, result;

   // special operands and alignment order against the running sum
   always_comb begin
      cc = classify(sum_ff);
      uc = unpack(sum_ff);
      kc = msb_pos({40'b0, uc.mant});
      my = {37'b0, uc.mant} << (6'd60 - kc);
      ey = uc.exp + exp_type'({6'b0, kc});

      spec_v_in    = 1'b1;
      spec_bits_in = QNAN_BITS;
      if (item_ff.nan || cc.nan) begin
         spec_bits_in = QNAN_BITS;
      end else if (item_ff.inf) begin
         if (cc.inf && (sum_ff[31] != item_ff.sign)) begin
            spec_bits_in = QNAN_BITS;
         end else begin
            spec_bits_in = {item_ff.sign, INF_BITS[30:0]};
         end
      end else if (cc.inf) begin
         spec_bits_in = sum_ff;
      end else if (item_ff.zero) begin
         spec_bits_in = cc.zero ? {item_ff.sign & sum_ff[31], 31'b0} : sum_ff;
      end else begin
         spec_v_in = 1'b0;
      end

      swap = !cc.zero && ((ey > item_ff.exp) || ((ey == item_ff.exp) && (my > item_ff.mant)));
      if (swap) begin
         big_m_in   = my;
         big_e_in   = ey;
         big_s_in   = sum_ff[31];
         small_m_in = item_ff.mant;
         small_e_in = item_ff.exp;
         small_s_in = item_ff.sign;
      end else begin
         big_m_in   = item_ff.mant;
         big_e_in   = item_ff.exp;
         big_s_in   = item_ff.sign;
         small_m_in = cc.zero ? '0 : my;
         small_e_in = cc.zero ? item_ff.exp : ey;
         small_s_in = sum_ff[31];
      end
   end

   // align with sticky, then add or subtract
   always_comb begin
      d  = big_e_ff - small_e_ff;
      sh = d[5:0];
      if (d > exp_type'(62)) begin
         ys = {{(MANT_W-1){1'b0}}, |small_m_ff};
      end else begin
         ys = small_m_ff >> sh;
         ys[0] = ys[0] | ((ys << sh) != small_m_ff);
      end
      if (big_s_ff == small_s_ff) begin
         r_in = {1'b0, big_m_ff} + {1'b0, ys};
      end else begin
         r_in = {1'b0, big_m_ff} - {1'b0, ys};
      end
   end

   always_comb begin
      p       = msb_pos({2'b0, r_ff});
      rn_in   = r_ff << (6'd61 - p);
      top_in  = big_e_ff + exp_type'({6'b0, p}) - exp_type'(60);
      zero_in = (r_ff == '0);
   end

   // round to nearest even, subnormal results share the -149 lsb
   always_comb begin
      diff = exp_type'(-126) - top_ff;
      if (top_ff >= exp_type'(-126)) begin
         extra = 6'd0;
         lsb_e = top_ff - exp_type'(23);
      end else begin
         extra = (diff > exp_type'(63)) ? 6'd63 : diff[5:0];
         lsb_e = exp_type'(-149);
      end
      t        = rn_ff >> extra;
      sticky_x = (t << extra) != rn_ff;
      q        = t[61:38];
      guard    = t[37];
      rest     = (|t[36:0]) | sticky_x;
      up       = guard & (rest | q[0]);
      q2       = {1'b0, q} + {24'b0, up};
      if (q2[24]) begin
         qf   = q2[24:1];
         lsb2 = lsb_e + exp_type'(1);
      end else begin
         qf   = q2[23:0];
         lsb2 = lsb_e;
      end
      biased = lsb2 + exp_type'(150);
      if (qf[23]) begin
         if (biased >= exp_type'(255)) begin
            packed_bits = {big_s_ff, INF_BITS[30:0]};
         end else begin
            packed_bits = {big_s_ff, biased[7:0], qf[22:0]};
         end
      end else begin
         packed_bits = {big_s_ff, 8'b0, qf[22:0]};
      end
      if (spec_v_ff) begin
         result = spec_bits_ff;
      end else if (zero_ff) begin
         result = ZERO_BITS;
      end else begin
         result = packed_bits;
      end
   end

   assign rb_push = (state_ff == ST_ROUND) && item_ff.last;
   assign rb_pop  = rsp_pop && (rb_cnt_ff != '0);
   assign q_pop   = (state_ff inside {ST_IDLE, ST_ROUND}) && !q_empty &&
                    ((rb_cnt_ff + RSP_CNT_W'(rb_push)) < RSP_CNT_W'(RSP_DEPTH));

   always_comb begin
      sum_in   = sum_ff;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  state_in = q_pop ? ST_SWAP : ST_IDLE;
         ST_SWAP:  state_in = ST_ADD;
         ST_ADD:   state_in = ST_NORM;
         ST_NORM:  state_in = ST_ROUND;
         ST_ROUND: begin
            sum_in   = item_ff.last ? ZERO_BITS : result;
            state_in = q_pop ? ST_SWAP : ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= ZERO_BITS;
         rb_wr_ff  <= '0;
         rb_rd_ff  <= '0;
         rb_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         if (rb_push) begin
            rb_wr_ff <= rb_wr_ff + 1'b1;
         end
         if (rb_pop) begin
            rb_rd_ff <= rb_rd_ff + 1'b1;
         end
         rb_cnt_ff <= rb_cnt_ff + RSP_CNT_W'(rb_push) - RSP_CNT_W'(rb_pop);
      end
      if (q_pop) begin
         item_ff <= q_rdata;
      end
      if (state_ff == ST_SWAP) begin
         big_m_ff     <= big_m_in;
         big_e_ff     <= big_e_in;
         big_s_ff     <= big_s_in;
         small_m_ff   <= small_m_in;
         small_e_ff   <= small_e_in;
         small_s_ff   <= small_s_in;
         spec_v_ff    <= spec_v_in;
         spec_bits_ff <= spec_bits_in;
      end
      if (state_ff == ST_ADD) begin
         r_ff <= r_in;
      end
      if (state_ff == ST_NORM) begin
         rn_ff   <= rn_in;
         top_ff  <= top_in;
         zero_ff <= zero_in;
      end
      if (rb_push) begin
         rb_ff[rb_wr_ff] <= result;
      end
   end

   assign rsp_empty = (rb_cnt_ff == '0);
   assign rsp_sum   = rb_ff[rb_rd_ff];

`ifndef ASSERT_OFF
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE || state_ff == ST_ROUND))
      else $error("request taken while an update is in progress");
   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      rb_cnt_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result buffer count out of range");
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rb_push && !rb_pop && rb_cnt_ff == RSP_CNT_W'(RSP_DEPTH)))
      else $error("result buffer overflow");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && item_ff.last) |=> sum_ff == ZERO_BITS)
      else $error("running sum not cleared after last element");
`endif

endmodule

FILE: rtl/core/float_dot_product.sv
// A request passes the multiplier stages and the request queue, then the running-sum update;
// the sum after a request marked last is written to the result buffer. The running-sum update (swap,
// align/add, normalize, round) is a 4-step loop that each request must finish before the next.
// Requests are buffered in a 4-entry queue; results in a 2-entry buffer.
// Reset (synchronous): empties both queues and sets the running sum to +0.0.
module float_dot_product import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_a_bits,
   input  logic [31:0] req_b_bits,
   input  logic        req_last_element,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_sum_bits
);

   logic              accept;
   logic [1:0]        inflight;
   logic              q_push, q_pop, q_empty;
   prod_type          q_wdata, q_rdata;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   occupancy;

   // count requests in the multiplier stages against queue space
   assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(inflight);
   assign full      = occupancy >= (QCNT_W+1)'(QDEPTH);
   assign accept    = push && !full;

   fdp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_a     (req_a_bits),
      .in_b     (req_b_bits),
      .in_last  (req_last_element),
      .inflight (inflight),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   fdp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wdata   (q_wdata),
      .pop     (q_pop),
      .rdata   (q_rdata),
      .q_empty (q_empty),
      .count   (q_count)
   );

   fdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_sum   (rsp_sum_bits)
   );

endmodule
